FILE: src/wedl_pkg.sv
// package for the windowed energy drive limiter
// widths, reset values, register indexes and the action code shared by all files
// no dependencies

package wedl_pkg;

	// payload widths
	localparam int DRIVE_W     = 16;
	localparam int ENERGY_W    = 32;
	localparam int LIMIT_W     = 16;
	localparam int BOUND_W     = 15;
	localparam int SUM_OUT_W   = 38;
	localparam int ACTION_W    = 2;

	// configuration port
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_HIGH = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ENERGY_LOW  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_FLOOR = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_CEIL  = CFG_IDX_W'(3);

	// register reset values
	localparam logic [ENERGY_W-1:0] ENERGY_HIGH_RST = ENERGY_W'(1000000);
	localparam logic [ENERGY_W-1:0] ENERGY_LOW_RST  = ENERGY_W'(500000);
	localparam logic [BOUND_W-1:0]  LIMIT_FLOOR_RST = BOUND_W'(512);
	localparam logic [BOUND_W-1:0]  LIMIT_CEIL_RST  = BOUND_W'(2559);

	// hysteresis steps
	localparam logic signed [LIMIT_W-1:0] STEP_DOWN = LIMIT_W'(3);
	localparam logic signed [LIMIT_W-1:0] STEP_UP   = LIMIT_W'(1);

	localparam int DEFAULT_WINDOW_DEPTH = 64;

	typedef enum logic [ACTION_W-1:0] {
		ACT_HOLD    = 2'd0,
		ACT_REDUCE  = 2'd1,
		ACT_RECOVER = 2'd2
	} limit_action_t;

	// word handed to the window chain
	typedef struct packed {
		logic                shift;
		logic [ENERGY_W-1:0] energy;
	} win_push_t;

endpackage

FILE: src/wedl_if.sv
// valid/ready channel interfaces for the drive words and the result words
// depends on wedl_pkg

interface wedl_drive_if;
	import wedl_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] x_drive;
	logic signed [DRIVE_W-1:0] y_drive;

	modport source (output valid, output x_drive, output y_drive, input ready);
	modport sink   (input valid, input x_drive, input y_drive, output ready);
endinterface

interface wedl_result_if;
	import wedl_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [LIMIT_W-1:0] drive_limit;
	logic [SUM_OUT_W-1:0]      window_energy;
	logic [ACTION_W-1:0]       limit_action;

	modport source (output valid, output drive_limit, output window_energy,
		output limit_action, input ready);
	modport sink   (input valid, input drive_limit, input window_energy,
		input limit_action, output ready);
endinterface

FILE: src/windowed_energy_drive_limiter.sv
// top level of the windowed energy drive limiter
// depends on wedl_pkg, wedl_if (interfaces) and wedl_window
//
// channel      dir  word                                        handshake
// drive_in     in   x_drive, y_drive (16 b signed each)         valid/ready
// result_out   out  drive_limit, window_energy, limit_action    valid/ready
// cfg          in   cfg_we, cfg_index, cfg_wdata                write strobe
//
// one word per cycle sustained while the result side keeps taking words; a result is
// offered once its drive word has passed through every stage register
// the stages are the square stage, the window sum add, the threshold compare
// and the limit update stage, which each take one register
// the window cells and the sum clear asynchronously at reset, no clearing pass
// a stalled result holds in the output stage while earlier stages keep filling
// their bubbles, so input ready only drops once every stage is occupied

module windowed_energy_drive_limiter #(
	parameter int WINDOW_DEPTH = wedl_pkg::DEFAULT_WINDOW_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	wedl_drive_if.sink                      drive_in,
	wedl_result_if.source                   result_out,
	input  logic                            cfg_we,
	input  logic [wedl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wedl_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import wedl_pkg::*;

	localparam int SUM_W      = ENERGY_W + $clog2(WINDOW_DEPTH);
	localparam int DEPTH_BITS = $clog2(WINDOW_DEPTH + 1);
	localparam int PROD_W     = ENERGY_W + DEPTH_BITS;
	localparam logic [DEPTH_BITS-1:0] DEPTH_K = DEPTH_BITS'(WINDOW_DEPTH);
	localparam logic [PROD_W-1:0] THR_HIGH_RST =
		PROD_W'(ENERGY_HIGH_RST) * PROD_W'(DEPTH_K);
	localparam logic [PROD_W-1:0] THR_LOW_RST =
		PROD_W'(ENERGY_LOW_RST) * PROD_W'(DEPTH_K);

	// ---------------------------------------------------------------
	// configuration: thresholds are kept already scaled by the depth
	// ---------------------------------------------------------------
	logic [SUM_W-1:0]         thr_high_q;
	logic [SUM_W-1:0]         thr_low_q;
	logic [BOUND_W-1:0]       floor_q;
	logic [BOUND_W-1:0]       ceil_q;
	logic [PROD_W-1:0]        cfg_prod;
	logic                     ceil_wr;

	// per-sample limit times window depth, at most 32 by 7 bits at the default depth
	assign cfg_prod = PROD_W'(cfg_wdata[ENERGY_W-1:0]) * PROD_W'(DEPTH_K);
	assign ceil_wr  = cfg_we && (cfg_index == REG_LIMIT_CEIL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_high_q <= SUM_W'(THR_HIGH_RST);
			thr_low_q  <= SUM_W'(THR_LOW_RST);
			floor_q    <= LIMIT_FLOOR_RST;
			ceil_q     <= LIMIT_CEIL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENERGY_HIGH: thr_high_q <= SUM_W'(cfg_prod);
				REG_ENERGY_LOW:  thr_low_q  <= SUM_W'(cfg_prod);
				REG_LIMIT_FLOOR: floor_q    <= cfg_wdata[BOUND_W-1:0];
				REG_LIMIT_CEIL:  ceil_q     <= cfg_wdata[BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// stage flow: each stage loads when empty or when it empties ahead
	// ---------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy1, rdy2, rdy3, rdy4;
	logic ld1, ld2, ld3, ld4;

	assign rdy4 = !vld_s4 || result_out.ready;
	assign rdy3 = !vld_s3 || rdy4;
	assign rdy2 = !vld_s2 || rdy3;
	assign rdy1 = !vld_s1 || rdy2;

	assign ld1 = drive_in.valid && rdy1;
	assign ld2 = vld_s1 && rdy2;
	assign ld3 = vld_s2 && rdy3;
	assign ld4 = vld_s3 && rdy4;

	assign drive_in.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy1) vld_s1 <= drive_in.valid;
			if (rdy2) vld_s2 <= vld_s1;
			if (rdy3) vld_s3 <= vld_s2;
			if (rdy4) vld_s4 <= vld_s3;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: energy of the drive pair, two 16x16 squares and an add
	// ---------------------------------------------------------------
	logic signed [2*DRIVE_W-1:0] x_sq;
	logic signed [2*DRIVE_W-1:0] y_sq;
	logic [ENERGY_W-1:0]         energy;
	logic [ENERGY_W-1:0]         energy_s1;

	assign x_sq   = drive_in.x_drive * drive_in.x_drive;
	assign y_sq   = drive_in.y_drive * drive_in.y_drive;
	// each square is at most 2^30, so the sum fits 32 bits unsigned
	assign energy = ENERGY_W'($unsigned(x_sq)) + ENERGY_W'($unsigned(y_sq));

	always_ff @(posedge clk) begin
		if (ld1) begin
			energy_s1 <= energy;
		end
	end

	// ---------------------------------------------------------------
	// stage 2: window shift and running sum; the sum register is the
	// stage payload, it only moves when the next word enters
	// ---------------------------------------------------------------
	win_push_t        push;
	logic [SUM_W-1:0] sum_s2;

	assign push.shift  = ld2;
	assign push.energy = energy_s1;

	wedl_window #(
		.WINDOW_DEPTH (WINDOW_DEPTH)
	) u_window (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.sum    (sum_s2)
	);

	// ---------------------------------------------------------------
	// stage 3: strict compares against the scaled thresholds
	// ---------------------------------------------------------------
	logic [SUM_W-1:0] sum_s3;
	logic             over_s3;
	logic             under_s3;

	always_ff @(posedge clk) begin
		if (ld3) begin
			sum_s3   <= sum_s2;
			over_s3  <= sum_s2 > thr_high_q;
			under_s3 <= sum_s2 < thr_low_q;
		end
	end

	// ---------------------------------------------------------------
	// stage 4: hysteretic limit update, reduction wins when both hold;
	// the limit register doubles as the output payload
	// ---------------------------------------------------------------
	logic signed [LIMIT_W-1:0] limit_q;
	logic signed [LIMIT_W-1:0] limit_next;
	limit_action_t             action_next;
	limit_action_t             action_s4;
	logic [SUM_W-1:0]          sum_s4;
	logic signed [LIMIT_W-1:0] floor_s;
	logic signed [LIMIT_W-1:0] ceil_s;

	assign floor_s = $signed({1'b0, floor_q});
	assign ceil_s  = $signed({1'b0, ceil_q});

	always_comb begin
		limit_next  = limit_q;
		action_next = ACT_HOLD;
		if (over_s3) begin
			if (limit_q > floor_s) begin
				limit_next  = limit_q - STEP_DOWN;
				action_next = ACT_REDUCE;
			end
		end else if (under_s3) begin
			if (limit_q < ceil_s) begin
				limit_next  = limit_q + STEP_UP;
				action_next = ACT_RECOVER;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= $signed({1'b0, LIMIT_CEIL_RST});
		end else if (ceil_wr) begin
			// loading the ceiling also loads the limit
			limit_q <= $signed({1'b0, cfg_wdata[BOUND_W-1:0]});
		end else if (ld4) begin
			limit_q <= limit_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ld4) begin
			action_s4 <= action_next;
			sum_s4    <= sum_s3;
		end
	end

	assign result_out.valid         = vld_s4;
	assign result_out.drive_limit   = limit_q;
	assign result_out.window_energy = SUM_OUT_W'(sum_s4);
	assign result_out.limit_action  = action_s4;

	// ---------------------------------------------------------------
	// checks on the limit loop
	// ---------------------------------------------------------------
	a_reduce_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ld4 && !ceil_wr && action_next == ACT_REDUCE) |=>
			(limit_q == $past(limit_q) - STEP_DOWN))
		else $error("reduction did not step the limit down by three");

	a_recover_step: assert property (@(posedge clk) disable iff (!arst_n)
		(ld4 && !ceil_wr && action_next == ACT_RECOVER) |=>
			(limit_q == $past(limit_q) + STEP_UP))
		else $error("recovery did not step the limit up by one");

	a_hold_keeps_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(ld4 && !ceil_wr && action_next == ACT_HOLD) |=> $stable(limit_q))
		else $error("limit moved without an action");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s4 && !result_out.ready) |=> vld_s4 && $stable(sum_s4))
		else $error("stalled result lost or changed");

endmodule

FILE: src/wedl_cell.sv
// one cell of the energy window: holds one energy and passes it on when the window shifts
// depends on wedl_pkg

module wedl_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  logic [wedl_pkg::ENERGY_W-1:0] energy_in,
	output logic [wedl_pkg::ENERGY_W-1:0] energy_out
);
	import wedl_pkg::*;

	logic [ENERGY_W-1:0] energy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energy_q <= '0;
		end else if (shift) begin
			energy_q <= energy_in;
		end
	end

	assign energy_out = energy_q;

endmodule

FILE: src/wedl_window.sv
// sliding energy window as a row of cells plus the running window sum
// depends on wedl_pkg and wedl_cell

module wedl_window #(
	parameter int WINDOW_DEPTH = wedl_pkg::DEFAULT_WINDOW_DEPTH
) (
	input  logic                                                 clk,
	input  logic                                                 arst_n,
	input  wedl_pkg::win_push_t                                  push,
	output logic [wedl_pkg::ENERGY_W+$clog2(WINDOW_DEPTH)-1:0]   sum
);
	import wedl_pkg::*;

	localparam int SUM_W = ENERGY_W + $clog2(WINDOW_DEPTH);

	logic [ENERGY_W-1:0] tap [WINDOW_DEPTH+1];
	logic [SUM_W-1:0]    sum_q;

	assign tap[0] = push.energy;

	// newest energy enters cell 0, the oldest drops out of the last cell
	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		wedl_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (push.shift),
			.energy_in  (tap[i]),
			.energy_out (tap[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (push.shift) begin
			sum_q <= sum_q + SUM_W'(push.energy) - SUM_W'(tap[WINDOW_DEPTH]);
		end
	end

	assign sum = sum_q;

	// the sum holds every cell, so it can never be below the oldest one
	a_sum_covers_tail: assert property (@(posedge clk) disable iff (!arst_n)
		sum_q >= SUM_W'(tap[WINDOW_DEPTH]))
		else $error("window sum below oldest energy");

endmodule

FILE: tb/wedl_limit_checker.sv
`timescale 1ns / 100ps
// result checker for the windowed energy drive limiter: watches the drive, result and
// configuration ports, predicts every result word and compares it field by field
// depends on wedl_pkg and the wedl_drive_if / wedl_result_if interfaces

module wedl_limit_checker #(
	parameter int WINDOW_DEPTH = wedl_pkg::DEFAULT_WINDOW_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	wedl_drive_if                           drive_mon,
	wedl_result_if                          result_mon,
	input  logic                            cfg_we,
	input  logic [wedl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wedl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output int                              mismatches,
	output int                              outstanding
);
	import wedl_pkg::*;

	typedef struct packed {
		logic signed [LIMIT_W-1:0] limit;
		logic [SUM_OUT_W-1:0]      energy;
		limit_action_t             action;
	} limit_word_t;

	logic [ENERGY_W-1:0] high_per_sample;
	logic [ENERGY_W-1:0] low_per_sample;
	logic [BOUND_W-1:0]  floor_reg;
	logic [BOUND_W-1:0]  ceiling_reg;
	logic [ENERGY_W-1:0] energies [WINDOW_DEPTH];
	int                  slot;
	longint              running_sum;
	int                  limit_now;
	limit_word_t         results_due [$];

	// one drive word: window update, threshold compare, hysteresis step
	function automatic limit_word_t predict_limit(logic signed [DRIVE_W-1:0] xv,
			logic signed [DRIVE_W-1:0] yv);
		longint      e;
		longint      upper_thr;
		longint      lower_thr;
		limit_word_t r;
		e = longint'(xv) * longint'(xv) + longint'(yv) * longint'(yv);
		running_sum = running_sum - longint'(energies[slot]) + e;
		energies[slot] = e[ENERGY_W-1:0];
		slot = (slot + 1 == WINDOW_DEPTH) ? 0 : slot + 1;
		upper_thr = longint'(high_per_sample) * WINDOW_DEPTH;
		lower_thr = longint'(low_per_sample) * WINDOW_DEPTH;
		r.action = ACT_HOLD;
		// reduction wins when both thresholds are crossed
		if (running_sum > upper_thr) begin
			if (limit_now > int'(floor_reg)) begin
				limit_now = limit_now - int'(STEP_DOWN);
				r.action  = ACT_REDUCE;
			end
		end else if (running_sum < lower_thr) begin
			if (limit_now < int'(ceiling_reg)) begin
				limit_now = limit_now + int'(STEP_UP);
				r.action  = ACT_RECOVER;
			end
		end
		r.limit  = limit_now[LIMIT_W-1:0];
		r.energy = running_sum[SUM_OUT_W-1:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		limit_word_t exp_word;
		if (!arst_n) begin
			high_per_sample = ENERGY_HIGH_RST;
			low_per_sample  = ENERGY_LOW_RST;
			floor_reg       = LIMIT_FLOOR_RST;
			ceiling_reg     = LIMIT_CEIL_RST;
			foreach (energies[i]) energies[i] = '0;
			slot        = 0;
			running_sum = 0;
			limit_now   = int'(LIMIT_CEIL_RST);
			results_due.delete();
			outstanding = 0;
		end else begin
			if (result_mon.valid && result_mon.ready) begin
				if (results_due.size() == 0) begin
					$display("%0t: result word with nothing expected: limit %0d energy %0d action %0d",
						$time, result_mon.drive_limit, result_mon.window_energy,
						result_mon.limit_action);
					mismatches++;
				end else begin
					exp_word = results_due.pop_front();
					if (result_mon.drive_limit !== exp_word.limit) begin
						$display("%0t: drive_limit expected %0d got %0d", $time,
							exp_word.limit, result_mon.drive_limit);
						mismatches++;
					end
					if (result_mon.window_energy !== exp_word.energy) begin
						$display("%0t: window_energy expected %0d got %0d", $time,
							exp_word.energy, result_mon.window_energy);
						mismatches++;
					end
					if (result_mon.limit_action !== exp_word.action) begin
						$display("%0t: limit_action expected %0d got %0d", $time,
							exp_word.action, result_mon.limit_action);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ENERGY_HIGH: high_per_sample = cfg_wdata;
					REG_ENERGY_LOW:  low_per_sample  = cfg_wdata;
					REG_LIMIT_FLOOR: floor_reg       = cfg_wdata[BOUND_W-1:0];
					REG_LIMIT_CEIL: begin
						ceiling_reg = cfg_wdata[BOUND_W-1:0];
						limit_now   = int'(ceiling_reg);
					end
					default: ;
				endcase
			end
			if (drive_mon.valid && drive_mon.ready)
				results_due.push_back(predict_limit(drive_mon.x_drive, drive_mon.y_drive));
			outstanding = results_due.size();
		end
	end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// top of the windowed energy drive limiter testbench: clock, reset, drive word stimulus,
// register writes, result back-pressure, watchdog and verdict
// depends on wedl_pkg, wedl_if, windowed_energy_drive_limiter and wedl_limit_checker

module testbench;
	import wedl_pkg::*;

	// random part size and pacing
	localparam int ITEM_COUNT  = 1250;
	localparam int PHASES      = 10;
	localparam int HOLD_CYCLES = 200;   // long receiver hold-off, fills the pipeline
	localparam int IDLE_LIMIT  = 3000;  // cycles with no handshake before giving up
	localparam int DRAIN_WAIT  = 20;    // pipeline is 4 deep, leave plenty of slack

	// an index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(255);

	localparam logic [CFG_DATA_W-1:0] ENERGY_TOP = 32'h8000_0000;
	localparam int                    BOUND_TOP  = 32767;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	int errors;
	int pending;
	int idle_cycles = 0;
	int burst_left  = 0;
	bit steady      = 1'b0;  // no sender gaps in this phase
	bit stall_req   = 1'b0;
	bit stall_done  = 1'b0;

	wedl_drive_if  drive_ch ();
	wedl_result_if result_ch ();

	windowed_energy_drive_limiter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.drive_in   (drive_ch),
		.result_out (result_ch),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	wedl_limit_checker limit_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.drive_mon   (drive_ch),
		.result_mon  (result_ch),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (errors),
		.outstanding (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// every task below starts and ends just after a falling edge

	// offer one drive word and hold it until the block takes it
	task automatic send_word(input int xv, input int yv);
		drive_ch.valid   = 1'b1;
		drive_ch.x_drive = DRIVE_W'(xv);
		drive_ch.y_drive = DRIVE_W'(yv);
		do @(posedge clk); while (!drive_ch.ready);
		@(negedge clk);
	endtask

	task automatic pause(input int cycles);
		drive_ch.valid = 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// bursts of random length, random gaps in between unless the phase is steady
	task automatic send_paced(input int xv, input int yv);
		if (burst_left == 0) begin
			if (!steady && $urandom_range(0, 3) != 0)
				pause($urandom_range(1, 6));
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		send_word(xv, yv);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// floor and ceiling only keep 15 bits, so junk goes in the upper ones
	function automatic logic [CFG_DATA_W-1:0] bound_data(input int b);
		return ($urandom & ~CFG_DATA_W'(BOUND_TOP)) | CFG_DATA_W'(b);
	endfunction

	// registers may only change with the block empty
	task automatic settle();
		pause(0);
		wait (pending == 0);
		@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	function automatic int draw_axis(input int b);
		if (b == 0)
			return 0;
		return int'($urandom_range(0, 2 * b)) - b;
	endfunction

	// receiver: segments of always-ready, coin-flip, mostly-ready and a fixed
	// 3-of-4 pattern, plus one long hold-off when the stimulus asks for it
	initial begin
		int mode;
		int span;
		int tick;
		tick = 0;
		result_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			span = $urandom_range(20, 120);
			repeat (span) begin
				@(negedge clk);
				if (stall_req && !stall_done) begin
					result_ch.ready = 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
					stall_done = 1'b1;
				end
				tick++;
				case (mode)
					0: result_ch.ready = 1'b1;
					1: result_ch.ready = 1'($urandom_range(0, 1));
					2: result_ch.ready = ($urandom_range(0, 9) != 0);
					default: result_ch.ready = ((tick % 4) != 3);
				endcase
			end
		end
	end

	// watchdog: any handshake or register write counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((drive_ch.valid && drive_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("[windowed_energy_drive_limiter] ERROR");
				$finish;
			end
		end
	end

	initial begin
		int     bound;
		int     seg_left;
		bit     loud;
		int     pick;
		int     xv;
		int     yv;
		int     floor_v;
		int     ceil_v;
		longint base;
		logic [CFG_DATA_W-1:0] high_v;
		logic [CFG_DATA_W-1:0] low_v;
		logic [CFG_DATA_W-1:0] swap_v;

		drive_ch.valid   = 1'b0;
		drive_ch.x_drive = '0;
		drive_ch.y_drive = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: reset config, empty window, limit sits at the ceiling
		send_word(0, 0);
		settle();

		// sum exactly on both thresholds changes nothing, then steps down
		// past a zero floor to -2 and holds there
		cfg_write(REG_ENERGY_HIGH, 32'd1);
		cfg_write(REG_ENERGY_LOW, 32'd1);
		cfg_write(REG_LIMIT_FLOOR, bound_data(0));
		cfg_write(REG_LIMIT_CEIL, bound_data(4));
		cfg_write(REG_UNMAPPED, $urandom);
		send_word(8, 0);
		send_word(1, 0);
		send_word(0, 0);
		send_word(0, -1);
		// field extremes, all while the limit stays pinned at -2, below the floor
		send_word(-32768, -32768);
		send_word(32767, 32767);
		send_word(-32768, 32767);
		send_word(32767, -32768);
		send_word(-1, 1);
		send_word(1, -1);
		settle();

		// high below low: both crossed, reduction wins
		cfg_write(REG_ENERGY_HIGH, '0);
		cfg_write(REG_ENERGY_LOW, ENERGY_TOP);
		cfg_write(REG_LIMIT_CEIL, bound_data(10));
		send_word(12345, -23456);
		send_word(0, 0);
		settle();

		// thresholds at the top: recovery toward the ceiling
		cfg_write(REG_ENERGY_HIGH, ENERGY_TOP);
		send_word(-7, 300);
		send_word(0, 0);
		settle();

		// ceiling below floor: nothing moves either way
		cfg_write(REG_LIMIT_FLOOR, bound_data(200));
		cfg_write(REG_LIMIT_CEIL, bound_data(100));
		send_word(32767, 0);
		settle();
		cfg_write(REG_ENERGY_HIGH, '0);
		send_word(0, 32767);
		settle();

		// random phases: thresholds scaled to an amplitude, loud and quiet
		// stretches push the window sum back and forth across them
		for (int ph = 0; ph < PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0: bound = $urandom_range(1, 64);
				1: bound = $urandom_range(64, 1024);
				2: bound = $urandom_range(1024, 8192);
				default: bound = $urandom_range(8192, BOUND_TOP);
			endcase
			base   = longint'(bound) * bound;
			high_v = CFG_DATA_W'(base);
			low_v  = CFG_DATA_W'(base / 2);
			if ($urandom_range(0, 4) == 0) begin
				swap_v = high_v;
				high_v = low_v;
				low_v  = swap_v;
			end
			if ($urandom_range(0, 5) == 0)
				high_v = $urandom_range(0, 1) ? ENERGY_TOP : '0;
			if ($urandom_range(0, 5) == 0)
				low_v = $urandom_range(0, 1) ? ENERGY_TOP : '0;

			case ($urandom_range(0, 3))
				0: floor_v = 0;
				1: floor_v = BOUND_TOP;
				default: floor_v = $urandom_range(0, BOUND_TOP);
			endcase
			if ($urandom_range(0, 4) == 0)
				ceil_v = floor_v - int'($urandom_range(0, 90));
			else
				ceil_v = floor_v + int'($urandom_range(0, 90));
			if (ceil_v < 0)
				ceil_v = 0;
			if (ceil_v > BOUND_TOP)
				ceil_v = BOUND_TOP;

			cfg_write(REG_LIMIT_FLOOR, bound_data(floor_v));
			cfg_write(REG_ENERGY_HIGH, high_v);
			if ($urandom_range(0, 2) == 0)
				cfg_write(CFG_IDX_W'($urandom_range(int'(REG_LIMIT_CEIL) + 1, 255)), $urandom);
			cfg_write(REG_ENERGY_LOW, low_v);
			cfg_write(REG_LIMIT_CEIL, bound_data(ceil_v));

			steady = (ph % 3 == 0);
			// long hold-off on the result side while words keep coming
			if (ph == 2)
				stall_req = 1'b1;
			burst_left = 0;
			seg_left   = 0;
			loud       = 1'b0;
			for (int n = 0; n < ITEM_COUNT / PHASES; n++) begin
				if (seg_left == 0) begin
					loud     = !loud;
					seg_left = $urandom_range(16, 70);
				end
				seg_left--;
				pick = $urandom_range(0, 99);
				if (pick < 10) begin
					xv = int'($urandom_range(0, 65535)) - 32768;
					yv = int'($urandom_range(0, 65535)) - 32768;
				end else if (pick < 13) begin
					xv = $urandom_range(0, 1) ? -32768 : 32767;
					yv = $urandom_range(0, 1) ? -32768 : 32767;
				end else if (loud) begin
					xv = draw_axis((2 * bound > BOUND_TOP) ? BOUND_TOP : 2 * bound);
					yv = draw_axis((2 * bound > BOUND_TOP) ? BOUND_TOP : 2 * bound);
				end else begin
					xv = draw_axis(bound / 4);
					yv = draw_axis(bound / 4);
				end
				send_paced(xv, yv);
			end
			settle();
		end

		pause(0);
		wait (pending == 0);
		@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("[windowed_energy_drive_limiter] OK");
		else
			$display("[windowed_energy_drive_limiter] ERROR");
		$finish;
	end

endmodule
